// File: rtl/trbd_pkg.sv
// Shared types, codes and constants for the trust blob record deframer.
// Used by trbd_parse and trust_blob_record_deframer_top; depends on nothing else.
package trbd_pkg;

	// Default limits, handed to the top-level parameters.
	localparam int MAX_RECORDS_DEF    = 256;
	localparam int MAX_RECORD_LEN_DEF = 16384;

	// Header layout and framing constants.
	localparam logic [31:0] BLOB_MAGIC   = 32'h5452_5553;
	localparam logic [31:0] BLOB_VERSION = 32'd1;
	localparam int          HDR_BYTES    = 12;
	localparam int          MAGIC_END    = 3;
	localparam int          VERSION_END  = 7;

	// Field widths of one result item.
	localparam int POS_W    = 23;
	localparam int INDEX_W  = 8;
	localparam int LENGTH_W = 15;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 3;

	// Packed width of the result tdata, whole bytes.
	localparam int RES_BITS = STATUS_W + INDEX_W + POS_W + LENGTH_W + COUNT_W;
	localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// Final status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_SHORT_HDR,
		ST_BAD_MAGIC,
		ST_BAD_VERSION,
		ST_COUNT_BIG,
		ST_TRUNC_LEN,
		ST_BAD_LEN,
		ST_TRUNC_PAY
	} status_t;

	// Result kinds.
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_FINAL  = 1'b1;

	// One result item.
	typedef struct packed {
		logic                kind;
		status_t             status;
		logic [INDEX_W-1:0]  record_index;
		logic [POS_W-1:0]    record_offset;
		logic [LENGTH_W-1:0] record_length;
		logic [COUNT_W-1:0]  record_count;
	} res_t;

endpackage

// File: rtl/trbd_parse.sv
// Blob parser: holds the framing state and turns each accepted byte into at most one result.
// Depends on trbd_pkg.
module trbd_parse #(
	parameter int MAX_RECORDS    = trbd_pkg::MAX_RECORDS_DEF,
	parameter int MAX_RECORD_LEN = trbd_pkg::MAX_RECORD_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_en,
	input  logic [7:0]     byte_value,
	input  logic           is_last,
	output logic           res_valid,
	output trbd_pkg::res_t res
);
	import trbd_pkg::*;

	localparam int RW = $clog2(MAX_RECORDS + 1);
	localparam int LW = $clog2(MAX_RECORD_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// Framing state.
	phase_t          phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [23:0]     shift_q, shift_d;
	logic [1:0]      bin_q, bin_d;
	logic [RW-1:0]   decl_q, decl_d;
	logic [RW-1:0]   done_q, done_d;
	logic [LW-1:0]   left_q, left_d;
	status_t         err_q, err_d;

	logic [31:0]     word;
	logic            word_done;
	logic            rec;
	logic [LW-1:0]   left_dec;
	logic [RW-1:0]   done_inc;
	logic [POS_W-1:0] pos_inc;
	status_t         final_st;

	assign word      = {shift_q, byte_value};
	assign word_done = (bin_q == 2'd3);
	assign left_dec  = left_q - LW'(1);
	assign done_inc  = done_q + RW'(1);
	assign pos_inc   = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;

	// Next-state logic for one byte.
	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		bin_d   = bin_q;
		decl_d  = decl_q;
		done_d  = done_q;
		left_d  = left_q;
		err_d   = err_q;
		rec     = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				shift_d = word[23:0];
				bin_d   = bin_q + 2'd1;
				if (word_done) begin
					shift_d = '0;
					if (pos_q == POS_W'(MAGIC_END)) begin
						if (word != BLOB_MAGIC) begin
							phase_d = PH_ERROR;
							err_d   = ST_BAD_MAGIC;
						end
					end else if (pos_q == POS_W'(VERSION_END)) begin
						if (word != BLOB_VERSION) begin
							phase_d = PH_ERROR;
							err_d   = ST_BAD_VERSION;
						end
					end else if (word > 32'(MAX_RECORDS)) begin
						phase_d = PH_ERROR;
						err_d   = ST_COUNT_BIG;
					end else begin
						decl_d  = word[RW-1:0];
						phase_d = (word == 32'd0) ? PH_DONE : PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				shift_d = word[23:0];
				bin_d   = bin_q + 2'd1;
				if (word_done) begin
					shift_d = '0;
					if (word == 32'd0 || word > 32'(MAX_RECORD_LEN)) begin
						phase_d = PH_ERROR;
						err_d   = ST_BAD_LEN;
					end else begin
						rec     = 1'b1;
						left_d  = word[LW-1:0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					done_d  = done_inc;
					phase_d = (done_inc >= decl_q) ? PH_DONE : PH_LENGTH;
				end
			end
			default: begin
			end
		endcase
	end

	// Final status from the state as it stands after this byte.
	always_comb begin
		if (pos_q < POS_W'(HDR_BYTES - 1)) begin
			final_st = ST_SHORT_HDR;
		end else begin
			case (phase_d)
				PH_ERROR:   final_st = err_d;
				PH_DONE:    final_st = ST_OK;
				PH_LENGTH:  final_st = ST_TRUNC_LEN;
				PH_PAYLOAD: final_st = ST_TRUNC_PAY;
				default:    final_st = ST_SHORT_HDR;
			endcase
		end
	end

	// Result item for this byte; the final status takes precedence over a record.
	always_comb begin
		res_valid = byte_en & (is_last | rec);
		res       = '0;
		if (is_last) begin
			res.kind         = KIND_FINAL;
			res.status       = final_st;
			res.record_count = COUNT_W'(decl_d);
		end else begin
			res.kind          = KIND_RECORD;
			res.status        = ST_OK;
			res.record_index  = INDEX_W'(done_q);
			res.record_offset = pos_inc;
			res.record_length = word[LENGTH_W-1:0];
		end
	end

	// State registers; the final byte returns everything to the reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			shift_q <= '0;
			bin_q   <= '0;
			decl_q  <= '0;
			done_q  <= '0;
			left_q  <= '0;
			err_q   <= ST_OK;
		end else if (byte_en) begin
			if (is_last) begin
				phase_q <= PH_HEADER;
				pos_q   <= '0;
				shift_q <= '0;
				bin_q   <= '0;
				decl_q  <= '0;
				done_q  <= '0;
				left_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_inc;
				shift_q <= shift_d;
				bin_q   <= bin_d;
				decl_q  <= decl_d;
				done_q  <= done_d;
				left_q  <= left_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

// File: rtl/trust_blob_record_deframer_top.sv
// Top level of the trust blob record deframer: stream ports, parser and output buffering.
// Depends on trbd_pkg and trbd_parse.
//
// Channel  Dir  Handshake                 Payload
// s_axis   in   s_axis_tvalid/tready      tdata: byte_value; tlast: is_last
// m_axis   out  m_axis_tvalid/tready      tdata: status..record_count; tuser: kind
//
// One byte is taken every cycle while s_axis_tready is high; each result is registered before m_axis.
// The parser state update is a single compare-and-count step.
// An output register plus a one-entry skid register let input flow while a result waits;
// s_axis_tready drops only when both hold a result.
// arst_n clears the parser to the header phase and empties both result registers.
module trust_blob_record_deframer_top #(
	parameter int MAX_RECORDS    = trbd_pkg::MAX_RECORDS_DEF,
	parameter int MAX_RECORD_LEN = trbd_pkg::MAX_RECORD_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] byte_value
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [2:0] status, [10:3] record_index, [33:11] record_offset,
	// [48:34] record_length, [57:49] record_count, rest zero
	output logic [trbd_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                         m_axis_tuser   // [0] kind
);
	import trbd_pkg::*;

	logic byte_en;
	logic res_valid;
	res_t res;
	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic out_free;

	assign s_axis_tready = ~skid_valid_q;
	assign byte_en       = s_axis_tvalid & s_axis_tready;

	trbd_parse #(
		.MAX_RECORDS   (MAX_RECORDS),
		.MAX_RECORD_LEN(MAX_RECORD_LEN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.byte_value(s_axis_tdata),
		.is_last   (s_axis_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_free = ~out_valid_q | m_axis_tready;

	// Output and skid valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output and skid payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	// Pack the result item onto the master side.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = TDATA_W'({out_q.record_count, out_q.record_length,
		out_q.record_offset, out_q.record_index, out_q.status});

endmodule
